// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lks_pkg.sv =====
// ---------------------------------------------------------------------------
// Label keyword scanner package
// Field widths, character codes, result kinds and the result record.
// ---------------------------------------------------------------------------
package lks_pkg;

  localparam int MAX_LINE_DEF = 1024;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int LINE_W  = 24;
  localparam int COL_W   = 10;
  localparam int COUNT_W = 16;
  localparam int KW_LEN  = 6;
  localparam int PROG_W  = 3;

  localparam int DATA_FIELDS_W = LINE_W + COL_W + BYTE_W + COUNT_W;
  localparam int TDATA_W       = ((DATA_FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W         = TDATA_W - DATA_FIELDS_W;

  localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LINE_W-1:0]  line_number;
    logic [COL_W-1:0]   column;
    logic [BYTE_W-1:0]  text_byte;
    logic [COUNT_W-1:0] label_count;
  } res_t;

  // Byte of the keyword backslash-label at a given position.
  function automatic logic [BYTE_W-1:0] kw_byte(input logic [PROG_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = CH_BACKSLASH;
      3'd1:    ch = 8'h6C;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h62;
      3'd4:    ch = 8'h65;
      3'd5:    ch = 8'h6C;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/lks_scan.sv =====
// ---------------------------------------------------------------------------
// Label keyword scanner core
// Holds the line, column, match and phase state and forms the result for
// the byte presented on in_byte. State advances when en is high.
// ---------------------------------------------------------------------------
module lks_scan #(
  parameter int MAX_LINE = lks_pkg::MAX_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [lks_pkg::BYTE_W-1:0]  in_byte,
  output logic                        hit,
  output lks_pkg::res_t               res
);
  import lks_pkg::*;

  localparam int OFF_W = $clog2(MAX_LINE - 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(MAX_LINE - 2);

  typedef enum logic [1:0] {
    PH_SCAN  = 2'd0,
    PH_SKIP  = 2'd1,
    PH_LABEL = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  phase_t              phase, phase_next;
  logic [LINE_W-1:0]   current_line, current_line_next;
  logic [OFF_W-1:0]    byte_offset, byte_offset_next;
  logic [PROG_W-1:0]   match_progress, match_progress_next;
  logic [COUNT_W-1:0]  found_total, found_total_next;

  logic                chunk_end;
  logic                closes;
  logic [PROG_W-1:0]   prog_inc;

  always_comb begin
    chunk_end = (in_byte == CH_NEWLINE) || (byte_offset >= OFF_LAST);
    closes    = (in_byte == CH_NUL) || chunk_end ||
                ((phase == PH_LABEL) && (in_byte == CH_RBRACE));
    if (in_byte == kw_byte(match_progress)) begin
      prog_inc = match_progress + PROG_W'(1);
    end else if (in_byte == CH_BACKSLASH) begin
      prog_inc = PROG_W'(1);
    end else begin
      prog_inc = '0;
    end

    phase_next          = phase;
    match_progress_next = match_progress;
    found_total_next    = found_total;
    hit                 = 1'b0;
    res                 = '0;

    case (phase)
      PH_SCAN: begin
        if (in_byte == CH_NUL) begin
          phase_next          = PH_DONE;
          match_progress_next = '0;
        end else if (prog_inc == PROG_W'(KW_LEN)) begin
          match_progress_next = '0;
          if (found_total != '1) begin
            found_total_next = found_total + COUNT_W'(1);
          end
          hit             = 1'b1;
          res.kind        = KIND_START;
          res.line_number = current_line;
          res.column      = COL_W'(byte_offset - OFF_W'(KW_LEN - 1));
          phase_next      = PH_SKIP;
        end else begin
          match_progress_next = prog_inc;
        end
      end
      PH_SKIP, PH_LABEL: begin
        if (closes) begin
          hit             = 1'b1;
          res.kind        = KIND_END;
          res.label_count = found_total;
          phase_next      = PH_DONE;
        end else if (phase == PH_SKIP) begin
          phase_next = PH_LABEL;
        end else begin
          hit           = 1'b1;
          res.kind      = KIND_TEXT;
          res.text_byte = in_byte;
        end
      end
      default: begin
      end
    endcase

    if (chunk_end) begin
      byte_offset_next    = '0;
      current_line_next   = (current_line != '1) ? current_line + LINE_W'(1)
                                                 : current_line;
      phase_next          = PH_SCAN;
      match_progress_next = '0;
    end else begin
      byte_offset_next  = byte_offset + OFF_W'(1);
      current_line_next = current_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      current_line   <= LINE_W'(1);
      byte_offset    <= '0;
      match_progress <= '0;
      found_total    <= '0;
    end else if (en) begin
      phase          <= phase_next;
      current_line   <= current_line_next;
      byte_offset    <= byte_offset_next;
      match_progress <= match_progress_next;
      found_total    <= found_total_next;
    end
  end

endmodule

// ===== rtl/lks_obuf.sv =====
// ---------------------------------------------------------------------------
// Label keyword scanner result register
// Holds one result beat for the output channel and reports when it can
// take a new one.
// ---------------------------------------------------------------------------
module lks_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  lks_pkg::res_t  load_res,
  input  logic           take,
  output logic           room,
  output logic           valid,
  output lks_pkg::res_t  res
);
  import lks_pkg::*;

  assign room = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      res <= load_res;
    end
  end

endmodule

// ===== rtl/label_keyword_scanner_unit.sv =====
// ---------------------------------------------------------------------------
// Label keyword scanner unit
// Scans a text byte stream for the label keyword and streams out the label
// position, the label text bytes and a running label count.
//
// Input channel s_axis carries one text byte per beat. Output channel
// m_axis carries one result per beat: tuser gives the kind (start, text,
// end), tdata gives line number, column, text byte and label count.
// A byte is held in an input register and scanned there; its result (if
// any) is loaded into the result register once that register has room.
// Throughput is one byte per cycle while the result register has room;
// the scanner state loop updates once per byte and both registers can
// turn over in the same cycle.
// Bytes that cause no result still pass through the input register in
// order behind any pending result.
// Reset clears the line count to one, the column and label count to zero
// and empties both registers.
// When the receiver holds m_axis_tready low with a result waiting, the
// input register fills and s_axis_tready drops until the result is taken.
// ---------------------------------------------------------------------------
module label_keyword_scanner_unit #(
  parameter int MAX_LINE = lks_pkg::MAX_LINE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lks_pkg::BYTE_W-1:0]   s_axis_tdata,   // in_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lks_pkg::TDATA_W-1:0]  m_axis_tdata,   // line_number, column,
                                                       // text_byte, label_count
  output logic [lks_pkg::KIND_W-1:0]   m_axis_tuser    // kind
);
  import lks_pkg::*;

  `include "assert_macros.svh"

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              room;
  logic              hit;
  res_t              scan_res;
  res_t              out_res;

  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  lks_scan #(
    .MAX_LINE (MAX_LINE)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_byte (in_byte),
    .hit     (hit),
    .res     (scan_res)
  );

  lks_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && hit),
    .load_res (scan_res),
    .take     (m_axis_tready),
    .room     (room),
    .valid    (m_axis_tvalid),
    .res      (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_res.label_count, out_res.text_byte,
                         out_res.column, out_res.line_number};

  `ASSERT_IMPL(a_stall_only_when_blocked, !s_axis_tready,
               in_valid && m_axis_tvalid && !m_axis_tready,
               "input side stalled while the result register had room")

  `ASSERT_NEXT(a_held_byte_stable, in_valid && !advance,
               in_valid && $stable(in_byte),
               "held input byte changed or was dropped before it was scanned")

  `ASSERT_IMPL(a_end_counts_label, m_axis_tvalid && out_res.kind == KIND_END,
               out_res.label_count != '0,
               "label end result carries a zero label count")

endmodule
